>>> src/lpls_pkg.sv
// Package with the shared widths, codes and state encoding of the packed LED level store.
package lpls_pkg;

    // Default number of daisy-chained 16-channel drivers.
    localparam int CHIPS_DEF = 4;

    // Port widths: tdata is padded up to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    localparam int CHAN_W  = 7;
    localparam int VALUE_W = 12;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int DOT_W   = 6;

    typedef enum logic [2:0] {
        A_SET_LVL  = 3'd0,
        A_GET_LVL  = 3'd1,
        A_SET_DOT  = 3'd2,
        A_GET_DOT  = 3'd3,
        A_DUMP_LVL = 3'd4,
        A_DUMP_DOT = 3'd5
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HI,
        S_RD_LO,
        S_MOD,
        S_WR_LO,
        S_RESP,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

endpackage

>>> src/led_driver_packed_level_store.sv
// Top level of the packed LED level store: frame image memories and their sequencer.
//
//  Channel | Direction | Ports                              | Word contents
//  --------+-----------+------------------------------------+-------------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser  | one command: action, channel, value
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser  | one result: read value, frame word,
//          |           | m_tlast                            | status, last flag
//
// A get runs through two memory reads of the straddled window (S_RD_HI, S_RD_LO), a modify
// step (S_MOD) and an output step (S_RESP) that loads the result register. A set adds a step
// (S_WR_LO) to write the second word back, since each memory has a single write port. The
// sequencer goes back to S_IDLE before the next command is taken. A dump handles one stored
// word at a time, 6*CHIPS level words or 12*CHIPS dot bytes, each with a read step and an
// output step (S_DUMP_RD, S_DUMP_OUT). Reset clears the valid bits
// of both memories at once, so every entry reads as zero afterwards and no clearing pass is
// needed. A stall on the result side holds the sequencer in its output state; a new command
// is taken only when the previous one has put out its last word into the output register.
module led_driver_packed_level_store
    import lpls_pkg::*;
#(
    parameter int CHIPS = CHIPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: [6:0] channel, [18:7] value, rest zero.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: [2:0] action.
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: [11:0] read_value, [43:12] frame_word, rest zero.
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: [0] status (channel out of range).
    output logic [M_TUSER_W-1:0]  m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    localparam int NCHAN  = CHIPS * 16;
    localparam int NWORDS = CHIPS * 6;
    localparam int NBYTES = CHIPS * 12;
    localparam int LI     = $clog2(NWORDS);
    localparam int DI     = $clog2(NBYTES);
    // Address width covers one past the last byte, for the second word of a window.
    localparam int AW     = $clog2(NBYTES + 1);
    localparam int LOFF_W = $clog2(NCHAN * 12);
    localparam int DOFF_W = $clog2(NCHAN * 6);

    // Frame image memories with their per-entry valid bits.
    logic [WORD_W-1:0] lvl_mem [NWORDS];
    logic [BYTE_W-1:0] dot_mem [NBYTES];
    logic [NWORDS-1:0] lvl_vld_reg;
    logic [NBYTES-1:0] dot_vld_reg;
    logic [WORD_W-1:0] lvl_q_reg;
    logic [BYTE_W-1:0] dot_q_reg;
    logic              lvl_ok_q_reg;
    logic              dot_ok_q_reg;

    // Sequencer state and the command being worked on.
    state_t               state_reg, state_next;
    act_t                 act_reg;
    logic                 ok_reg;
    logic [AW-1:0]        addr_reg;
    logic [4:0]           bit_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [WORD_W-1:0]    hi_reg;
    logic [WORD_W-1:0]    lo_reg;
    logic [VALUE_W-1:0]   rv_reg;
    logic [AW-1:0]        cnt_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [VALUE_W-1:0]   m_rv_reg;
    logic [WORD_W-1:0]    m_fw_reg;
    logic                 m_st_reg;
    logic                 m_last_reg;

    // Decoded input command.
    act_t                 in_act;
    logic [CHAN_W-1:0]    in_chan;
    logic                 in_ok;
    logic [CHAN_W-1:0]    in_idx;
    logic [LOFF_W-1:0]    in_loff;
    logic [DOFF_W-1:0]    in_doff;

    // Control from the sequencer.
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 lvl_we;
    logic                 dot_we;
    logic [AW-1:0]        wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic                 emit;
    logic [VALUE_W-1:0]   emit_rv;
    logic [WORD_W-1:0]    emit_fw;
    logic                 emit_st;
    logic                 emit_last;

    // Window arithmetic.
    logic                 is_lvl;
    logic                 is_set;
    logic [AW-1:0]        addr_p1;
    logic [WORD_W-1:0]    lvl_rd;
    logic [BYTE_W-1:0]    dot_rd;
    logic [5:0]           sh_l;
    logic [3:0]           sh_d;
    logic [2*WORD_W-1:0]  win_l;
    logic [2*WORD_W-1:0]  new_l;
    logic [2*BYTE_W-1:0]  win_d;
    logic [2*BYTE_W-1:0]  new_d;
    logic [VALUE_W-1:0]   rv_l;
    logic [DOT_W-1:0]     rv_d;
    logic                 out_free;
    logic                 dump_last;

    assign in_act  = act_t'(s_tuser);
    assign in_chan = s_tdata[CHAN_W-1:0];
    assign in_ok   = (in_chan < NCHAN);
    // Channels are stored in reverse order, last channel first.
    assign in_idx  = in_ok ? CHAN_W'(NCHAN - 1 - int'(in_chan)) : '0;
    // Bit offsets: 12*idx for levels, 6*idx for dots.
    assign in_loff = LOFF_W'({in_idx, 3'b000}) + LOFF_W'({in_idx, 2'b00});
    assign in_doff = DOFF_W'({in_idx, 2'b00}) + DOFF_W'({in_idx, 1'b0});

    assign is_lvl = (act_reg == A_SET_LVL) || (act_reg == A_GET_LVL) ||
                    (act_reg == A_DUMP_LVL);
    assign is_set = (act_reg == A_SET_LVL) || (act_reg == A_SET_DOT);
    assign addr_p1 = addr_reg + AW'(1);

    // Entries never written read as zero.
    assign lvl_rd = lvl_ok_q_reg ? lvl_q_reg : '0;
    assign dot_rd = dot_ok_q_reg ? dot_q_reg : '0;

    // The first word sits in the upper half of the window, the field below the MSB by its offset.
    assign sh_l  = 6'd52 - 6'(bit_reg);
    assign sh_d  = 4'd10 - 4'(bit_reg[2:0]);
    assign win_l = {hi_reg, lvl_rd};
    assign win_d = {hi_reg[BYTE_W-1:0], dot_rd};
    assign rv_l  = VALUE_W'(win_l >> sh_l);
    assign rv_d  = DOT_W'(win_d >> sh_d);
    assign new_l = (win_l & ~(64'hFFF << sh_l)) | ((2*WORD_W)'(val_reg) << sh_l);
    assign new_d = (win_d & ~(16'h003F << sh_d)) | ((2*BYTE_W)'(val_reg[DOT_W-1:0]) << sh_d);

    assign out_free  = !m_valid_reg || m_tready;
    assign dump_last = is_lvl ? (cnt_reg == AW'(NWORDS - 1)) : (cnt_reg == AW'(NBYTES - 1));

    always_comb begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = addr_reg;
        lvl_we     = 1'b0;
        dot_we     = 1'b0;
        wr_addr    = addr_reg;
        wr_data    = is_lvl ? new_l[2*WORD_W-1:WORD_W] : WORD_W'(new_d[2*BYTE_W-1:BYTE_W]);
        emit       = 1'b0;
        emit_rv    = '0;
        emit_fw    = '0;
        emit_st    = 1'b0;
        emit_last  = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_act)
                        A_SET_LVL, A_GET_LVL, A_SET_DOT, A_GET_DOT: state_next = S_RD_HI;
                        A_DUMP_LVL, A_DUMP_DOT:                     state_next = S_DUMP_RD;
                        default:                                    state_next = S_IDLE;
                    endcase
                end
            end
            S_RD_HI: begin
                rd_en      = 1'b1;
                state_next = S_RD_LO;
            end
            S_RD_LO: begin
                rd_en      = 1'b1;
                rd_addr    = addr_p1;
                state_next = S_MOD;
            end
            S_MOD: begin
                if (is_set && ok_reg) begin
                    lvl_we = is_lvl;
                    dot_we = !is_lvl;
                end
                state_next = is_set ? S_WR_LO : S_RESP;
            end
            S_WR_LO: begin
                wr_addr = addr_p1;
                wr_data = lo_reg;
                if (ok_reg) begin
                    lvl_we = is_lvl && (addr_p1 < AW'(NWORDS));
                    dot_we = !is_lvl && (addr_p1 < AW'(NBYTES));
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_rv    = rv_reg;
                    emit_st    = !ok_reg;
                    state_next = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                rd_en      = 1'b1;
                rd_addr    = cnt_reg;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_fw    = is_lvl ? lvl_rd : WORD_W'(dot_rd);
                    emit_last  = dump_last;
                    state_next = dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory arrays: one write and one registered read per cycle each.
    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[wr_addr[LI-1:0]] <= wr_data;
        end
        if (rd_en) begin
            lvl_q_reg <= lvl_mem[rd_addr[LI-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (dot_we) begin
            dot_mem[wr_addr[DI-1:0]] <= wr_data[BYTE_W-1:0];
        end
        if (rd_en) begin
            dot_q_reg <= dot_mem[rd_addr[DI-1:0]];
        end
    end

    // Control state, valid bits and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            lvl_vld_reg  <= '0;
            dot_vld_reg  <= '0;
            lvl_ok_q_reg <= 1'b0;
            dot_ok_q_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (lvl_we) begin
                lvl_vld_reg[wr_addr[LI-1:0]] <= 1'b1;
            end
            if (dot_we) begin
                dot_vld_reg[wr_addr[DI-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                lvl_ok_q_reg <= (rd_addr < AW'(NWORDS)) ? lvl_vld_reg[rd_addr[LI-1:0]] : 1'b0;
                dot_ok_q_reg <= (rd_addr < AW'(NBYTES)) ? dot_vld_reg[rd_addr[DI-1:0]] : 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Command and window registers.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            act_reg <= in_act;
            ok_reg  <= in_ok;
            val_reg <= s_tdata[CHAN_W +: VALUE_W];
            cnt_reg <= '0;
            if ((in_act == A_SET_DOT) || (in_act == A_GET_DOT)) begin
                addr_reg <= AW'(in_doff >> 3);
                bit_reg  <= 5'(in_doff[2:0]);
            end else begin
                addr_reg <= AW'(in_loff >> 5);
                bit_reg  <= in_loff[4:0];
            end
        end
        if (state_reg == S_RD_LO) begin
            hi_reg <= is_lvl ? lvl_rd : WORD_W'(dot_rd);
        end
        if (state_reg == S_MOD) begin
            lo_reg <= is_lvl ? new_l[WORD_W-1:0] : WORD_W'(new_d[BYTE_W-1:0]);
            if (ok_reg && !is_set) begin
                rv_reg <= is_lvl ? rv_l : VALUE_W'(rv_d);
            end else begin
                rv_reg <= '0;
            end
        end
        if (state_reg == S_DUMP_OUT && emit) begin
            cnt_reg <= cnt_reg + AW'(1);
        end
        if (emit) begin
            m_rv_reg   <= emit_rv;
            m_fw_reg   <= emit_fw;
            m_st_reg   <= emit_st;
            m_last_reg <= emit_last;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_fw_reg, m_rv_reg});
    assign m_tuser  = m_st_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> src/lpls_chk.sv
// Port checker for the packed LED level store, bound to the top level.
module lpls_chk
    import lpls_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    // A stalled result word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // A valid command keeps the block busy for at least the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == A_SET_LVL || s_tuser == A_GET_LVL ||
        s_tuser == A_SET_DOT || s_tuser == A_GET_DOT || s_tuser == A_DUMP_LVL ||
        s_tuser == A_DUMP_DOT) |=> !s_tready)
        else $error("command accepted while another is in progress");

    // An out-of-range channel gives an empty, final word.
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("error result carries data");

    // A dumped word never comes with a read value or an error flag.
    a_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[43:12] != '0) |-> !m_tuser[0] && (m_tdata[11:0] == '0))
        else $error("dump word mixed with channel result");

endmodule

bind led_driver_packed_level_store lpls_chk u_lpls_chk (.*);
